// ----- sv/relr_relocation_decoder_assert.svh -----
// Assertion macros used by the RELR decoder top level.
`ifndef RELR_RELOCATION_DECODER_ASSERT_SVH
`define RELR_RELOCATION_DECODER_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, checked out of reset.
`define RELR_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("relr assertion failed");
// Next-cycle implication, checked out of reset.
`define RELR_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("relr assertion failed");
`else
`define RELR_ASSERT_IMPL(label, clk, rstn, ante, cons)
`define RELR_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif
`endif

// ----- sv/relr_pkg.sv -----
// Types, constants and helpers shared by the RELR decoder modules.
`timescale 1ns / 1ps
package relr_pkg;
    localparam int ADDR_W     = 64;
    localparam int MAP_W      = 63;
    localparam int IDX_W      = 6;
    localparam logic [ADDR_W-1:0] WORD_BYTES  = 64'd8;
    localparam logic [ADDR_W-1:0] BITMAP_SPAN = 64'd504;

    // One decoded run: first word address and the set of words to patch
    typedef struct packed {
        logic [ADDR_W-1:0] start;
        logic [MAP_W-1:0]  map;
    } relr_cmd_t;

    // Queue occupancy flags
    typedef struct packed {
        logic full;
        logic empty;
    } relr_q_stat_t;

    // Index of the lowest set bit (zero when none is set)
    function automatic logic [IDX_W-1:0] low_idx(input logic [MAP_W-1:0] m);
        logic [IDX_W-1:0] r;
        r = '0;
        for (int i = MAP_W - 1; i >= 0; i--) begin
            if (m[i]) r = IDX_W'(i);
        end
        return r;
    endfunction
endpackage

// ----- sv/relr_front.sv -----
// Front end: accepts RELR words, tracks the running base, queues runs.
`timescale 1ns / 1ps
module relr_front
    import relr_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [ADDR_W-1:0]   s_tdata,   // [63:0] entry
    input  logic                s_tuser,   // [0] table_start
    input  relr_q_stat_t        q_stat,
    output logic                q_push,
    output relr_cmd_t           q_wdata
);
    logic [ADDR_W-1:0] run_base_reg, run_base_next;
    logic [ADDR_W-1:0] base_cur;
    logic              accept;
    logic              is_map;

    assign s_tready = !q_stat.full;
    assign accept   = s_tvalid && s_tready;
    assign is_map   = s_tdata[0];
    assign base_cur = s_tuser ? '0 : run_base_reg;

    // Address words become a one-word run; empty bitmaps queue nothing
    always_comb begin
        if (is_map) begin
            q_wdata.start = base_cur;
            q_wdata.map   = s_tdata[ADDR_W-1:1];
        end else begin
            q_wdata.start = s_tdata;
            q_wdata.map   = MAP_W'(1);
        end
        q_push = accept && !(is_map && (s_tdata[ADDR_W-1:1] == '0));
    end

    // Running base update
    always_comb begin
        run_base_next = run_base_reg;
        if (accept) begin
            run_base_next = is_map ? (base_cur + BITMAP_SPAN) : (s_tdata + WORD_BYTES);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_base_reg <= '0;
        end else begin
            run_base_reg <= run_base_next;
        end
    end
endmodule

// ----- sv/relr_fifo.sv -----
// Small command queue between front and back end.
`timescale 1ns / 1ps
module relr_fifo
    import relr_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         push,
    input  relr_cmd_t    wdata,
    input  logic         pop,
    output relr_cmd_t    rdata,
    output relr_q_stat_t stat
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    relr_cmd_t        mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    assign stat.full  = (cnt_reg == FULL_CNT);
    assign stat.empty = (cnt_reg == '0);
    assign rdata      = mem[rd_ptr_reg];

    // Pointer and count update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push) wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)  rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop) cnt_next = cnt_reg + 1'b1;
        if (pop && !push) cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Storage
    always_ff @(posedge aclk) begin
        if (push) mem[wr_ptr_reg] <= wdata;
    end
endmodule

// ----- sv/relr_back.sv -----
// Back end: walks each queued run and emits biased target addresses.
`timescale 1ns / 1ps
module relr_back
    import relr_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic [ADDR_W-1:0]   reloc_bias,
    input  relr_q_stat_t        q_stat,
    input  relr_cmd_t           q_rdata,
    output logic                q_pop,
    output logic                busy,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [ADDR_W-1:0]   m_tdata,   // [63:0] target_addr
    output logic                m_tlast    // last
);
    logic              busy_reg, busy_next;
    logic [ADDR_W-1:0] base_reg;
    logic [MAP_W-1:0]  map_reg, map_next;
    logic              vld_reg, vld_next;
    logic [ADDR_W-1:0] addr_reg;
    logic              last_reg;
    logic              emit;
    logic [IDX_W-1:0]  idx;
    logic [ADDR_W-1:0] offs;

    assign q_pop    = !busy_reg && !q_stat.empty;
    assign emit     = busy_reg && (!vld_reg || m_tready);
    assign idx      = low_idx(map_reg);
    assign offs     = {{(ADDR_W - IDX_W - 3){1'b0}}, idx, 3'b000};
    assign map_next = map_reg & (map_reg - 1'b1);
    assign busy     = busy_reg;
    assign m_tvalid = vld_reg;
    assign m_tdata  = addr_reg;
    assign m_tlast  = last_reg;

    // Control: load a run, then one beat per set bit
    always_comb begin
        busy_next = busy_reg;
        vld_next  = vld_reg;
        if (m_tready) vld_next = 1'b0;
        if (q_pop) busy_next = 1'b1;
        if (emit) begin
            vld_next  = 1'b1;
            busy_next = (map_next != '0);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            vld_reg  <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            vld_reg  <= vld_next;
        end
    end

    // Datapath: bias added once per run, word offset per beat
    always_ff @(posedge aclk) begin
        if (q_pop) begin
            base_reg <= q_rdata.start + reloc_bias;
            map_reg  <= q_rdata.map;
        end else if (emit) begin
            map_reg  <= map_next;
        end
        if (emit) begin
            addr_reg <= base_reg + offs;
            last_reg <= (map_next == '0);
        end
    end
endmodule

// ----- sv/relr_relocation_decoder.sv -----
// Top level of the RELR relative-relocation decoder.
// An address word passes through the queue, the back-end load and the output register.
// Throughput: the back-end walker loads one queued run at a time, then clears one bitmap bit
// a cycle while m_tready does not stall it, emitting one result per set bit.
// Words are accepted while the FIFO_DEPTH-deep queue (default 4) has room; empty bitmaps take no back-end time.
// Reset (aresetn low, synchronous) clears the running base, load bias, queue and output.
`timescale 1ns / 1ps
`include "relr_relocation_decoder_assert.svh"
module relr_relocation_decoder
    import relr_pkg::*;
#(
    parameter int FIFO_DEPTH = 4
) (
    input  logic                aclk,
    input  logic                aresetn,
    // input stream
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [ADDR_W-1:0]   s_tdata,   // [63:0] entry
    input  logic                s_tuser,   // [0] table_start
    // result stream
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [ADDR_W-1:0]   m_tdata,   // [63:0] target_addr
    output logic                m_tlast,
    // configuration
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [3:0]          paddr,
    input  logic [63:0]         pwdata,
    output logic [63:0]         prdata,
    output logic                pready
);
    localparam logic REG_RELOC_BIAS = 1'b0;

    logic [ADDR_W-1:0] reloc_bias_reg, reloc_bias_next;
    relr_q_stat_t      q_stat;
    relr_cmd_t         q_wdata, q_rdata;
    logic              q_push, q_pop;
    logic              back_busy;
    logic              cfg_wr;

    // Register file
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = (paddr[3] == REG_RELOC_BIAS) ? reloc_bias_reg : '0;

    always_comb begin
        reloc_bias_next = reloc_bias_reg;
        if (cfg_wr && (paddr[3] == REG_RELOC_BIAS)) reloc_bias_next = pwdata;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            reloc_bias_reg <= '0;
        end else begin
            reloc_bias_reg <= reloc_bias_next;
        end
    end

    relr_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_stat   (q_stat),
        .q_push   (q_push),
        .q_wdata  (q_wdata)
    );

    relr_fifo #(.DEPTH(FIFO_DEPTH)) u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .wdata   (q_wdata),
        .pop     (q_pop),
        .rdata   (q_rdata),
        .stat    (q_stat)
    );

    relr_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .reloc_bias (reloc_bias_reg),
        .q_stat     (q_stat),
        .q_rdata    (q_rdata),
        .q_pop      (q_pop),
        .busy       (back_busy),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast)
    );

    // Queue is never overrun or underrun
    `RELR_ASSERT_IMPL(a_no_push_full, aclk, aresetn, q_push, !q_stat.full)
    `RELR_ASSERT_IMPL(a_no_pop_empty, aclk, aresetn, q_pop, !q_stat.empty)
    // A beat that is not the last of its run leaves the walker busy
    `RELR_ASSERT_IMPL(a_mid_run_busy, aclk, aresetn, m_tvalid && !m_tlast, back_busy)
endmodule
